@@ hdl/msh_pkg.sv @@
// ----------------------------------------------------------------------------
// msh_pkg
// Widths, limits and register indexes for the motor stall homing sequencer.
// ----------------------------------------------------------------------------
package msh_pkg;

	localparam int unsigned POSITION_BITS = 16;
	localparam int unsigned TIMER_BITS    = 12;
	localparam int unsigned LIMIT_BITS    = 5;
	localparam int unsigned SPEED_BITS    = 7;
	localparam int unsigned SAMPLE_BITS   = 8;
	localparam int unsigned PHASE_BITS    = 3;
	localparam int unsigned CFG_IDX_BITS  = 3;
	localparam int unsigned CFG_DATA_BITS = 12;

	localparam logic [SPEED_BITS-1:0] SPEED_MAX   = SPEED_BITS'(100);
	localparam logic [LIMIT_BITS-1:0] COUNT_MAX   = '1;
	localparam logic [TIMER_BITS-1:0] TIMER_MAX   = '1;

	localparam logic [LIMIT_BITS-1:0]  RST_STALL_LIMIT    = LIMIT_BITS'(20);
	localparam logic [SPEED_BITS-1:0]  RST_HOMING_SPEED   = SPEED_BITS'(70);
	localparam logic [SPEED_BITS-1:0]  RST_CENTRING_SPEED = SPEED_BITS'(60);
	localparam logic [TIMER_BITS-1:0]  RST_SETTLE_TICKS   = TIMER_BITS'(100);
	localparam logic [SAMPLE_BITS-1:0] RST_SAMPLE_TICKS   = SAMPLE_BITS'(5);
	localparam logic [TIMER_BITS-1:0]  RST_PAUSE_TICKS    = TIMER_BITS'(1000);

	localparam logic [CFG_IDX_BITS-1:0] CFG_STALL_LIMIT    = CFG_IDX_BITS'(0);
	localparam logic [CFG_IDX_BITS-1:0] CFG_HOMING_SPEED   = CFG_IDX_BITS'(1);
	localparam logic [CFG_IDX_BITS-1:0] CFG_CENTRING_SPEED = CFG_IDX_BITS'(2);
	localparam logic [CFG_IDX_BITS-1:0] CFG_SETTLE_TICKS   = CFG_IDX_BITS'(3);
	localparam logic [CFG_IDX_BITS-1:0] CFG_SAMPLE_TICKS   = CFG_IDX_BITS'(4);
	localparam logic [CFG_IDX_BITS-1:0] CFG_PAUSE_TICKS    = CFG_IDX_BITS'(5);

endpackage

@@ hdl/motor_stall_homing_sequencer_top.sv @@
// ----------------------------------------------------------------------------
// motor_stall_homing_sequencer_top
// Tick-driven homing: seek right edge by stall, pause, seek left edge and
// latch width, pause, return to the centre.
//
// channel   direction  handshake             payload
// in        input      in_valid / in_stall   start_req, position
// out       output     out_valid / out_stall motor_*, encoder_*, width, phase
// cfg       input      cfg_we                cfg_index, cfg_data
//
// One tick per clock unless the output side stalls: input register,
// combinational state update, result register.
// The input stage stalls only while a result waits in the output register
// and the output side stalls.
// Reset restores register defaults and returns the sequencer to idle.
// ----------------------------------------------------------------------------
module motor_stall_homing_sequencer_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              start_req,
	input  logic signed [msh_pkg::POSITION_BITS-1:0] position,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              motor_enable,
	output logic                              motor_reverse,
	output logic [msh_pkg::SPEED_BITS-1:0]    motor_speed,
	output logic                              encoder_enable,
	output logic                              encoder_clear,
	output logic signed [msh_pkg::POSITION_BITS-1:0] measured_width,
	output logic [msh_pkg::PHASE_BITS-1:0]    phase,
	output logic                              done_res,
	input  logic                              cfg_we,
	input  logic [msh_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [msh_pkg::CFG_DATA_BITS-1:0] cfg_data
);
	import msh_pkg::*;

	typedef enum logic [PHASE_BITS-1:0] {
		PH_IDLE    = 3'd0,
		PH_SEEK_R  = 3'd1,
		PH_PAUSE_R = 3'd2,
		PH_SEEK_L  = 3'd3,
		PH_PAUSE_L = 3'd4,
		PH_CENTRE  = 3'd5,
		PH_DONE    = 3'd6
	} phase_t;

	logic [LIMIT_BITS-1:0]  stall_limit_q;
	logic [SPEED_BITS-1:0]  homing_speed_q;
	logic [SPEED_BITS-1:0]  centring_speed_q;
	logic [TIMER_BITS-1:0]  settle_ticks_q;
	logic [SAMPLE_BITS-1:0] sample_ticks_q;
	logic [TIMER_BITS-1:0]  pause_ticks_q;

	phase_t                         phase_q;
	logic [TIMER_BITS-1:0]          timer_q;
	logic [LIMIT_BITS-1:0]          count_q;
	logic [POSITION_BITS-1:0]       last_q;
	logic signed [POSITION_BITS-1:0] width_q;
	logic                           settled_q;
	logic                           enc_on_q;

	logic                           valid_s1;
	logic                           start_s1;
	logic signed [POSITION_BITS-1:0] pos_s1;

	logic                           valid_s2;
	logic                           enable_s2;
	logic                           reverse_s2;
	logic [SPEED_BITS-1:0]          speed_s2;
	logic                           enc_en_s2;
	logic                           clear_s2;
	logic signed [POSITION_BITS-1:0] width_s2;
	phase_t                         phase_s2;

	logic                           adv;
	logic                           seek;
	logic                           seek_hit;
	logic [TIMER_BITS-1:0]          tinc;
	logic [LIMIT_BITS-1:0]          cnt_next;
	logic signed [POSITION_BITS-1:0] width_adj;
	logic signed [POSITION_BITS-1:0] centre;

	phase_t                         phase_d;
	logic [TIMER_BITS-1:0]          timer_d;
	logic [LIMIT_BITS-1:0]          count_d;
	logic [POSITION_BITS-1:0]       last_d;
	logic signed [POSITION_BITS-1:0] width_d;
	logic                           settled_d;
	logic                           enc_on_d;
	logic                           clear_d;
	logic [SPEED_BITS-1:0]          speed_d;
	logic                           rev_d;

	assign adv      = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stall_limit_q    <= RST_STALL_LIMIT;
			homing_speed_q   <= RST_HOMING_SPEED;
			centring_speed_q <= RST_CENTRING_SPEED;
			settle_ticks_q   <= RST_SETTLE_TICKS;
			sample_ticks_q   <= RST_SAMPLE_TICKS;
			pause_ticks_q    <= RST_PAUSE_TICKS;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_STALL_LIMIT:    stall_limit_q    <= cfg_data[LIMIT_BITS-1:0];
				CFG_HOMING_SPEED:   homing_speed_q   <= cfg_data[SPEED_BITS-1:0];
				CFG_CENTRING_SPEED: centring_speed_q <= cfg_data[SPEED_BITS-1:0];
				CFG_SETTLE_TICKS:   settle_ticks_q   <= cfg_data[TIMER_BITS-1:0];
				CFG_SAMPLE_TICKS:   sample_ticks_q   <= cfg_data[SAMPLE_BITS-1:0];
				CFG_PAUSE_TICKS:    pause_ticks_q    <= cfg_data[TIMER_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			start_s1 <= start_req;
			pos_s1   <= position;
		end
	end

	assign tinc      = (timer_q == TIMER_MAX) ? timer_q : timer_q + 1'b1;
	assign cnt_next  = (pos_s1 == last_q && count_q != COUNT_MAX) ? count_q + 1'b1 : count_q;
	assign width_adj = width_q + $signed({{(POSITION_BITS-1){1'b0}}, width_q[POSITION_BITS-1]});
	assign centre    = width_adj >>> 1;
	assign seek      = (phase_q == PH_SEEK_R) || (phase_q == PH_SEEK_L);

	always_comb begin
		phase_d   = phase_q;
		timer_d   = timer_q;
		count_d   = count_q;
		last_d    = last_q;
		width_d   = width_q;
		settled_d = settled_q;
		enc_on_d  = enc_on_q;
		clear_d   = 1'b0;
		seek_hit  = 1'b0;

		if (seek) begin
			if (!settled_q) begin
				if (tinc >= settle_ticks_q) begin
					settled_d = 1'b1;
					timer_d   = '0;
				end else begin
					timer_d = tinc;
				end
			end else if (tinc < TIMER_BITS'(sample_ticks_q)) begin
				timer_d = tinc;
			end else begin
				timer_d  = '0;
				count_d  = cnt_next;
				last_d   = pos_s1;
				seek_hit = cnt_next >= stall_limit_q;
			end
		end

		unique case (phase_q)
			PH_SEEK_R: begin
				if (seek_hit) begin
					phase_d = PH_PAUSE_R;
					timer_d = '0;
					clear_d = 1'b1;
				end
			end
			PH_SEEK_L: begin
				if (seek_hit) begin
					width_d = pos_s1;
					phase_d = PH_PAUSE_L;
					timer_d = '0;
				end
			end
			PH_PAUSE_R, PH_PAUSE_L: begin
				if (tinc >= pause_ticks_q) begin
					phase_d   = (phase_q == PH_PAUSE_R) ? PH_SEEK_L : PH_CENTRE;
					timer_d   = '0;
					count_d   = '0;
					last_d    = '0;
					settled_d = 1'b0;
				end else begin
					timer_d = tinc;
				end
			end
			PH_CENTRE: begin
				if (!settled_q) begin
					timer_d = tinc;
					if (tinc >= settle_ticks_q) begin
						settled_d = 1'b1;
						if (width_q <= centre)
							phase_d = PH_DONE;
					end
				end else if (pos_s1 <= centre) begin
					phase_d = PH_DONE;
				end
			end
			default: begin
				if (phase_q != PH_DONE)
					phase_d = PH_IDLE;
				if (start_s1) begin
					enc_on_d  = 1'b1;
					phase_d   = PH_SEEK_R;
					timer_d   = '0;
					count_d   = '0;
					last_d    = '0;
					settled_d = 1'b0;
				end
			end
		endcase

		speed_d = '0;
		rev_d   = 1'b0;
		unique case (phase_d)
			PH_SEEK_R: begin
				speed_d = (homing_speed_q > SPEED_MAX) ? SPEED_MAX : homing_speed_q;
				rev_d   = 1'b1;
			end
			PH_SEEK_L: begin
				speed_d = (homing_speed_q > SPEED_MAX) ? SPEED_MAX : homing_speed_q;
			end
			PH_CENTRE: begin
				speed_d = (centring_speed_q > SPEED_MAX) ? SPEED_MAX : centring_speed_q;
				rev_d   = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			timer_q   <= '0;
			count_q   <= '0;
			last_q    <= '0;
			width_q   <= '0;
			settled_q <= 1'b0;
			enc_on_q  <= 1'b0;
			valid_s2  <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				phase_q   <= phase_d;
				timer_q   <= timer_d;
				count_q   <= count_d;
				last_q    <= last_d;
				width_q   <= width_d;
				settled_q <= settled_d;
				enc_on_q  <= enc_on_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			enable_s2  <= speed_d != '0;
			reverse_s2 <= (speed_d != '0) && rev_d;
			speed_s2   <= speed_d;
			enc_en_s2  <= enc_on_d;
			clear_s2   <= clear_d;
			width_s2   <= width_d;
			phase_s2   <= phase_d;
		end
	end

	assign out_valid      = valid_s2;
	assign motor_enable   = enable_s2;
	assign motor_reverse  = reverse_s2;
	assign motor_speed    = speed_s2;
	assign encoder_enable = enc_en_s2;
	assign encoder_clear  = clear_s2;
	assign measured_width = width_s2;
	assign phase          = phase_s2;
	assign done_res       = phase_s2 == PH_DONE;

	a_clear_in_pause: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && encoder_clear |-> phase == PH_PAUSE_R)
		else $error("encoder clear outside right-edge stop");

	a_reverse_needs_enable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && motor_reverse |-> motor_enable)
		else $error("reverse without enable");

	a_speed_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> motor_speed <= SPEED_MAX)
		else $error("speed above clamp");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && valid_s2 && out_stall)
		else $error("input stalled without a blocked result");

	a_state_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |=> $stable(phase_q) && $stable(width_q))
		else $error("state moved without a tick");

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the motor stall homing sequencer. A short directed
// table walks the register extremes and the corner cases of a homing run.
// Random runs follow, steered by the predicted sequencer phase so that most
// runs reach the edges and the centre. Every result transfer is checked
// field by field against a typed row's result or an in-bench predictor.
// ----------------------------------------------------------------------------
module testbench;

	import msh_pkg::*;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int RANDOM_TICKS  = 1550;
	localparam int SQUEEZE_AFTER = 400;

	typedef enum logic [PHASE_BITS-1:0] {
		PH_IDLE, PH_SEEK_RIGHT, PH_PAUSE_RIGHT, PH_SEEK_LEFT, PH_PAUSE_LEFT,
		PH_CENTRE, PH_DONE
	} phase_t;

	typedef struct packed {
		logic                            en;
		logic                            rev;
		logic [SPEED_BITS-1:0]           spd;
		logic                            enc;
		logic                            clr;
		logic signed [POSITION_BITS-1:0] wid;
		logic [PHASE_BITS-1:0]           ph;
		logic                            done;
	} tick_result_t;

	typedef struct packed {
		logic                            is_cfg;
		logic [CFG_IDX_BITS-1:0]         idx;
		logic [CFG_DATA_BITS-1:0]        data;
		logic                            start;
		logic signed [POSITION_BITS-1:0] pos;
		logic                            typed;
		tick_result_t                    res;
	} plan_row_t;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            in_valid = 1'b0;
	logic                            in_stall;
	logic                            start_req = 1'b0;
	logic signed [POSITION_BITS-1:0] position = '0;
	logic                            out_valid;
	logic                            out_stall = 1'b0;
	logic                            motor_enable;
	logic                            motor_reverse;
	logic [SPEED_BITS-1:0]           motor_speed;
	logic                            encoder_enable;
	logic                            encoder_clear;
	logic signed [POSITION_BITS-1:0] measured_width;
	logic [PHASE_BITS-1:0]           phase;
	logic                            done_res;
	logic                            cfg_we = 1'b0;
	logic [CFG_IDX_BITS-1:0]         cfg_index = '0;
	logic [CFG_DATA_BITS-1:0]        cfg_data = '0;

	// predictor state and register copies
	phase_t                          seq_phase = PH_IDLE;
	int                              seq_timer = 0;
	int                              same_count = 0;
	logic [POSITION_BITS-1:0]        prev_pos = '0;
	logic signed [POSITION_BITS-1:0] width_q = '0;
	bit                              settled = 1'b0;
	bit                              enc_on = 1'b0;
	int                              stall_lim = RST_STALL_LIMIT;
	int                              homing_spd = RST_HOMING_SPEED;
	int                              centring_spd = RST_CENTRING_SPEED;
	int                              settle_len = RST_SETTLE_TICKS;
	int                              sample_per = RST_SAMPLE_TICKS;
	int                              pause_len = RST_PAUSE_TICKS;

	tick_result_t                    pending_outputs[$];
	plan_row_t                       plan[$];
	logic signed [POSITION_BITS-1:0] hold_pos = '0;
	bit                              send_burst = 1'b0;
	bit                              sink_burst = 1'b0;
	bit                              squeezed = 1'b0;
	int                              stall_left = 0;
	int                              errors = 0;
	int                              ticks_sent = 0;
	int                              results_seen = 0;
	int                              reg_writes = 0;
	int                              widths_latched = 0;
	int                              runs_centred = 0;
	int                              cycle_count = 0;

	motor_stall_homing_sequencer_top dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.start_req      (start_req),
		.position       (position),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.motor_enable   (motor_enable),
		.motor_reverse  (motor_reverse),
		.motor_speed    (motor_speed),
		.encoder_enable (encoder_enable),
		.encoder_clear  (encoder_clear),
		.measured_width (measured_width),
		.phase          (phase),
		.done_res       (done_res),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("testbench NOT OK");
			$finish;
		end
	end

	function automatic void bump_timer();
		if (seq_timer < TIMER_MAX)
			seq_timer++;
	endfunction

	function automatic void begin_drive(input phase_t ph);
		seq_phase = ph;
		seq_timer = 0;
		same_count = 0;
		prev_pos = '0;
		settled = 1'b0;
	endfunction

	function automatic bit seek_step(input logic [POSITION_BITS-1:0] p);
		bump_timer();
		if (!settled) begin
			if (seq_timer >= settle_len) begin
				settled = 1'b1;
				seq_timer = 0;
			end
			return 1'b0;
		end
		if (seq_timer < sample_per)
			return 1'b0;
		seq_timer = 0;
		if (p == prev_pos && same_count < COUNT_MAX)
			same_count++;
		prev_pos = p;
		return same_count >= stall_lim;
	endfunction

	function automatic tick_result_t step_sequencer(input bit s,
			input logic signed [POSITION_BITS-1:0] p);
		tick_result_t r;
		bit clr;
		bit rev;
		int spd;
		int centre;
		int pv;
		int wv;
		clr = 1'b0;
		rev = 1'b0;
		spd = 0;
		pv = p;
		wv = width_q;
		centre = wv / 2;
		case (seq_phase)
			PH_SEEK_RIGHT: begin
				if (seek_step(p)) begin
					seq_phase = PH_PAUSE_RIGHT;
					seq_timer = 0;
					clr = 1'b1;
				end
			end
			PH_PAUSE_RIGHT: begin
				bump_timer();
				if (seq_timer >= pause_len)
					begin_drive(PH_SEEK_LEFT);
			end
			PH_SEEK_LEFT: begin
				if (seek_step(p)) begin
					width_q = p;
					seq_phase = PH_PAUSE_LEFT;
					seq_timer = 0;
					widths_latched++;
				end
			end
			PH_PAUSE_LEFT: begin
				bump_timer();
				if (seq_timer >= pause_len)
					begin_drive(PH_CENTRE);
			end
			PH_CENTRE: begin
				if (!settled) begin
					bump_timer();
					if (seq_timer >= settle_len) begin
						settled = 1'b1;
						if (wv <= centre)
							seq_phase = PH_DONE;
					end
				end else if (pv <= centre) begin
					seq_phase = PH_DONE;
				end
				if (seq_phase == PH_DONE)
					runs_centred++;
			end
			default: begin
				if (s) begin
					enc_on = 1'b1;
					begin_drive(PH_SEEK_RIGHT);
				end
			end
		endcase
		case (seq_phase)
			PH_SEEK_RIGHT: begin
				spd = homing_spd > SPEED_MAX ? SPEED_MAX : homing_spd;
				rev = 1'b1;
			end
			PH_SEEK_LEFT: spd = homing_spd > SPEED_MAX ? SPEED_MAX : homing_spd;
			PH_CENTRE: begin
				spd = centring_spd > SPEED_MAX ? SPEED_MAX : centring_spd;
				rev = 1'b1;
			end
			default: spd = 0;
		endcase
		r.en = spd != 0;
		r.rev = spd != 0 && rev;
		r.spd = spd[SPEED_BITS-1:0];
		r.enc = enc_on;
		r.clr = clr;
		r.wid = width_q;
		r.ph = seq_phase;
		r.done = seq_phase == PH_DONE;
		return r;
	endfunction

	function automatic void apply_reg(input logic [CFG_IDX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] val);
		case (idx)
			CFG_STALL_LIMIT:    stall_lim = val[LIMIT_BITS-1:0];
			CFG_HOMING_SPEED:   homing_spd = val[SPEED_BITS-1:0];
			CFG_CENTRING_SPEED: centring_spd = val[SPEED_BITS-1:0];
			CFG_SETTLE_TICKS:   settle_len = val[TIMER_BITS-1:0];
			CFG_SAMPLE_TICKS:   sample_per = val[SAMPLE_BITS-1:0];
			CFG_PAUSE_TICKS:    pause_len = val[TIMER_BITS-1:0];
			default: ;
		endcase
	endfunction

	function automatic void add_row(input bit is_cfg, input logic [CFG_IDX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] val, input bit s,
			input logic signed [POSITION_BITS-1:0] p, input bit typed,
			input tick_result_t res);
		plan_row_t row;
		row.is_cfg = is_cfg;
		row.idx = idx;
		row.data = val;
		row.start = s;
		row.pos = p;
		row.typed = typed;
		row.res = res;
		plan.push_back(row);
	endfunction

	function automatic void add_cfg(input logic [CFG_IDX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] val);
		add_row(1'b1, idx, val, 1'b0, '0, 1'b0, '0);
	endfunction

	function automatic void add_tick(input bit s, input logic signed [POSITION_BITS-1:0] p);
		add_row(1'b0, '0, '0, s, p, 1'b0, '0);
	endfunction

	function automatic int pick_speed();
		case ($urandom_range(0, 3))
			0: return 0;
			1: return SPEED_MAX;
			2: return 127;
			default: return $urandom_range(1, 127);
		endcase
	endfunction

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] val);
		in_valid <= 1'b0;
		while (pending_outputs.size() != 0)
			@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		apply_reg(idx, val);
		reg_writes++;
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drive_tick(input bit s, input logic signed [POSITION_BITS-1:0] p,
			input bit typed, input tick_result_t known);
		int gap;
		int r;
		tick_result_t pred;
		if ($urandom_range(0, 79) == 0)
			send_burst = !send_burst;
		gap = 0;
		if (!send_burst) begin
			r = $urandom_range(0, 99);
			if (r >= 90)
				gap = $urandom_range(8, 25);
			else if (r >= 55)
				gap = $urandom_range(1, 3);
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		start_req <= s;
		position <= p;
		do
			@(posedge clk);
		while (in_stall);
		pred = step_sequencer(s, p);
		pending_outputs.push_back(typed ? known : pred);
		ticks_sent++;
	endtask

	// steer stimulus from the predicted phase: hold still while seeking,
	// hover around the half width while centring
	task automatic random_tick();
		bit s;
		logic signed [POSITION_BITS-1:0] p;
		int c;
		s = 1'b0;
		p = POSITION_BITS'($urandom);
		if ($urandom_range(0, 9) == 0) begin
			s = 1'($urandom);
		end else begin
			case (seq_phase)
				PH_IDLE, PH_DONE: s = $urandom_range(0, 3) == 0;
				PH_SEEK_RIGHT, PH_SEEK_LEFT: begin
					if ($urandom_range(0, 11) == 0) begin
						case ($urandom_range(0, 5))
							0: hold_pos = 16'sh7fff;
							1: hold_pos = 16'sh8000;
							2: hold_pos = '0;
							default: hold_pos = POSITION_BITS'($urandom);
						endcase
					end
					p = hold_pos;
					s = 1'($urandom);
				end
				PH_CENTRE: begin
					c = int'(width_q) / 2 + int'($urandom_range(0, 8)) - 3;
					p = c[POSITION_BITS-1:0];
					s = 1'($urandom);
				end
				default: s = 1'($urandom);
			endcase
		end
		drive_tick(s, p, 1'b0, '0);
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			errors++;
		end
	endtask

	initial begin : result_sink
		tick_result_t want;
		int r;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				if (pending_outputs.size() == 0) begin
					$display("%0t: result transfer with nothing expected", $time);
					errors++;
				end else begin
					want = pending_outputs.pop_front();
					check_field("motor_enable", want.en, motor_enable);
					check_field("motor_reverse", want.rev, motor_reverse);
					check_field("motor_speed", want.spd, motor_speed);
					check_field("encoder_enable", want.enc, encoder_enable);
					check_field("encoder_clear", want.clr, encoder_clear);
					check_field("measured_width", $signed(want.wid), $signed(measured_width));
					check_field("phase", want.ph, phase);
					check_field("done_res", want.done, done_res);
				end
				results_seen++;
			end
			if ($urandom_range(0, 149) == 0)
				sink_burst = !sink_burst;
			// hold off long enough to back up the input
			if (!squeezed && results_seen >= SQUEEZE_AFTER) begin
				squeezed = 1'b1;
				stall_left = 64;
			end
			r = $urandom_range(0, 99);
			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else if (sink_burst || r < 55) begin
				out_stall <= 1'b0;
			end else begin
				out_stall <= 1'b1;
				stall_left = (r < 92) ? $urandom_range(0, 2) : $urandom_range(8, 30);
			end
		end
	end

	initial begin : stimulus
		plan_row_t row;
		tick_result_t idle_res;
		tick_result_t first_seek;
		int setting;
		int len;
		int lim_v;
		int smp_v;
		int set_v;
		int pau_v;
		int hs_v;
		int cs_v;
		int random_start;
		idle_res = '{1'b0, 1'b0, 7'd0, 1'b0, 1'b0, 16'sd0, PH_IDLE, 1'b0};
		first_seek = '{1'b1, 1'b1, 7'd70, 1'b1, 1'b0, 16'sd0, PH_SEEK_RIGHT, 1'b0};
		add_row(1'b0, '0, '0, 1'b0, 16'sh7fff, 1'b1, idle_res);
		add_row(1'b0, '0, '0, 1'b0, 16'sh8000, 1'b1, idle_res);
		add_row(1'b0, '0, '0, 1'b1, 16'sh8000, 1'b1, first_seek);
		add_tick(1'b1, 16'sd0);
		add_cfg(CFG_STALL_LIMIT, 12'd0);
		add_cfg(CFG_SAMPLE_TICKS, 12'd0);
		add_cfg(CFG_SETTLE_TICKS, 12'd0);
		add_cfg(CFG_PAUSE_TICKS, 12'd0);
		add_cfg(CFG_HOMING_SPEED, 12'd127);
		add_cfg(CFG_CENTRING_SPEED, 12'd0);
		add_tick(1'b0, 16'sd5);
		add_tick(1'b0, 16'sd5);
		add_tick(1'b0, 16'sd0);
		add_tick(1'b0, 16'sd0);
		add_tick(1'b0, 16'sh8000);
		add_tick(1'b0, 16'sd0);
		add_tick(1'b0, 16'sd0);
		add_tick(1'b1, 16'sd0);
		add_cfg(CFG_STALL_LIMIT, 12'd1);
		add_cfg(CFG_SAMPLE_TICKS, 12'd1);
		add_cfg(CFG_SETTLE_TICKS, 12'd1);
		add_cfg(CFG_PAUSE_TICKS, 12'd1);
		add_cfg(CFG_HOMING_SPEED, 12'd0);
		add_cfg(CFG_CENTRING_SPEED, 12'd100);
		add_tick(1'b0, 16'sd9);
		add_tick(1'b0, 16'sh7fff);
		add_tick(1'b0, 16'sh7fff);
		add_tick(1'b0, 16'sd3);
		add_tick(1'b0, 16'sd3);
		add_tick(1'b0, 16'sh7fff);
		add_tick(1'b0, 16'sh7fff);
		add_tick(1'b0, 16'sd0);
		add_tick(1'b0, 16'sh7fff);
		add_tick(1'b0, 16'sd16384);
		add_tick(1'b0, 16'sd16383);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			row = plan[i];
			if (row.is_cfg)
				write_reg(row.idx, row.data);
			else
				drive_tick(row.start, row.pos, row.typed, row.res);
		end

		random_start = ticks_sent;
		for (setting = 0; ticks_sent - random_start < RANDOM_TICKS; setting++) begin
			if (setting == 1) begin
				lim_v = 31;
				smp_v = 255;
				set_v = 4095;
				pau_v = 4095;
				hs_v = 100;
				cs_v = 127;
				len = 120;
			end else begin
				lim_v = ($urandom_range(0, 7) == 0) ? 31 : $urandom_range(0, 6);
				smp_v = $urandom_range(0, 3);
				set_v = $urandom_range(0, 8);
				pau_v = $urandom_range(0, 8);
				hs_v = pick_speed();
				cs_v = pick_speed();
				len = $urandom_range(60, 160);
			end
			write_reg(CFG_STALL_LIMIT, CFG_DATA_BITS'(lim_v));
			write_reg(CFG_HOMING_SPEED, CFG_DATA_BITS'(hs_v));
			write_reg(CFG_CENTRING_SPEED, CFG_DATA_BITS'(cs_v));
			write_reg(CFG_SETTLE_TICKS, CFG_DATA_BITS'(set_v));
			write_reg(CFG_SAMPLE_TICKS, CFG_DATA_BITS'(smp_v));
			write_reg(CFG_PAUSE_TICKS, CFG_DATA_BITS'(pau_v));
			repeat (len) random_tick();
		end

		in_valid <= 1'b0;
		while (pending_outputs.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("ticks: %0d, results checked: %0d, register writes: %0d",
			ticks_sent, results_seen, reg_writes);
		$display("widths latched: %0d, runs centred: %0d, mismatches: %0d",
			widths_latched, runs_centred, errors);
		if (errors == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule

@@ filelist.f @@
hdl/msh_pkg.sv
hdl/motor_stall_homing_sequencer_top.sv
tb/testbench.sv
